FILE: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

  localparam int FIELD_W     = 32;
  localparam int DEF_WAYS    = 8;
  localparam int DEF_KEY_W   = 32;
  localparam int DEF_VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic shift_all;
    logic shift_on_hit;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/lkv_cell.sv
// One entry of the recency chain: holds a word and hands it to the next entry on a shift.
module lkv_cell import lkv_pkg::*; #(
  parameter int KEY_WIDTH   = DEF_KEY_W,
  parameter int VALUE_WIDTH = DEF_VALUE_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [KEY_WIDTH-1:0]   cmp_key,
  input  logic                   seen_in,
  output logic                   seen_out,
  output logic                   match,
  input  logic                   prev_valid,
  input  logic [KEY_WIDTH-1:0]   prev_key,
  input  logic [VALUE_WIDTH-1:0] prev_value,
  output logic                   valid,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value
);

  logic equal;
  logic shift;

  assign equal    = valid && (key == cmp_key);
  assign match    = equal && !seen_in;
  assign seen_out = seen_in || equal;
  assign shift    = ctrl.shift_all || (ctrl.shift_on_hit && !seen_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.clear && shift) begin
      key   <= prev_key;
      value <= prev_value;
    end
  end

endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level: fully associative key/value cache with true LRU order kept by a chain of entries.
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready   | opcode, lookup_key, new_value
//   output  | out_valid / out_ready | hit, read_value, evicted
//
// One word per cycle while the output is not stalled: all entries compare in parallel and the
// chain shifts in the same cycle. The result is registered when the word is taken.
// A new word is taken whenever the output register is empty or being drained.
// Reset empties the chain; entry data is left as it was.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int WAYS        = DEF_WAYS,
  parameter int KEY_WIDTH   = DEF_KEY_W,
  parameter int VALUE_WIDTH = DEF_VALUE_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [FIELD_W-1:0] lookup_key,
  input  logic [FIELD_W-1:0] new_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [FIELD_W-1:0] read_value,
  output logic               evicted
);

  logic                   accept;
  opcode_t                op;
  cell_ctrl_t             ctrl;
  logic [KEY_WIDTH-1:0]   key_in;
  logic [VALUE_WIDTH-1:0] value_in;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [VALUE_WIDTH-1:0] front_value;
  logic [FIELD_W-1:0]     hit_value_out;
  logic                   hit_any;
  logic                   is_lookup;
  logic                   is_insert;
  logic                   is_flush;

  logic [WAYS:0]          seen;
  logic [WAYS-1:0]        cell_match;
  logic [WAYS-1:0]        cell_valid;
  logic [KEY_WIDTH-1:0]   cell_key   [WAYS];
  logic [VALUE_WIDTH-1:0] cell_value [WAYS];

  generate
    if (KEY_WIDTH <= FIELD_W) begin : g_key_trunc
      assign key_in = lookup_key[KEY_WIDTH-1:0];
    end else begin : g_key_ext
      assign key_in = {{(KEY_WIDTH-FIELD_W){1'b0}}, lookup_key};
    end
    if (VALUE_WIDTH <= FIELD_W) begin : g_val_trunc
      assign value_in      = new_value[VALUE_WIDTH-1:0];
      assign hit_value_out = FIELD_W'(hit_value);
    end else begin : g_val_ext
      assign value_in      = {{(VALUE_WIDTH-FIELD_W){1'b0}}, new_value};
      assign hit_value_out = hit_value[FIELD_W-1:0];
    end
  endgenerate

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = opcode_t'(opcode);

  always_comb begin
    is_lookup = 1'b0;
    is_insert = 1'b0;
    is_flush  = 1'b0;
    unique case (op)
      OP_LOOKUP: is_lookup = 1'b1;
      OP_INSERT: is_insert = 1'b1;
      OP_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  assign hit_any           = seen[WAYS];
  assign ctrl.shift_all    = accept && is_insert;
  assign ctrl.shift_on_hit = accept && is_lookup && hit_any;
  assign ctrl.clear        = accept && is_flush;
  assign front_value       = is_insert ? value_in : hit_value;
  assign seen[0]           = 1'b0;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (cell_match[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < WAYS; g++) begin : g_cell
      logic                   prev_valid;
      logic [KEY_WIDTH-1:0]   prev_key;
      logic [VALUE_WIDTH-1:0] prev_value;

      if (g == 0) begin : g_front
        assign prev_valid = 1'b1;
        assign prev_key   = key_in;
        assign prev_value = front_value;
      end else begin : g_link
        assign prev_valid = cell_valid[g-1];
        assign prev_key   = cell_key[g-1];
        assign prev_value = cell_value[g-1];
      end

      lkv_cell #(
        .KEY_WIDTH  (KEY_WIDTH),
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .cmp_key   (key_in),
        .seen_in   (seen[g]),
        .seen_out  (seen[g+1]),
        .match     (cell_match[g]),
        .prev_valid(prev_valid),
        .prev_key  (prev_key),
        .prev_value(prev_value),
        .valid     (cell_valid[g]),
        .key       (cell_key[g]),
        .value     (cell_value[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit        <= is_lookup && hit_any;
      read_value <= (is_lookup && hit_any) ? hit_value_out : '0;
      evicted    <= is_insert && cell_valid[WAYS-1];
    end
  end

`ifndef SYNTHESIS
  a_hit_not_evicted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and evicted both set");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + {{(WAYS-1){1'b0}}, 1'b1})) == '0)
    else $error("occupied entries do not form a prefix");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_FLUSH) |=> cell_valid == '0)
    else $error("flush left entries occupied");

  a_insert_front: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_INSERT) |=> cell_valid[0])
    else $error("insert did not fill the front entry");
`endif

endmodule
